[design/keyed_value_table_assert.svh]
// Assertion macros for the keyed value table.
`ifndef KEYED_VALUE_TABLE_ASSERT_SVH
`define KEYED_VALUE_TABLE_ASSERT_SVH
`ifndef SYNTHESIS
`define KVT_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define KVT_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define KVT_ASSERT(lbl, clk, rstn, prop, msg)
`define KVT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

[design/kvt_pkg.sv]
// Types and constants shared by the keyed value table files.
`timescale 1ns / 1ps
`default_nettype none

package kvt_pkg;

    localparam int KEY_W = 8;
    localparam int VAL_W = 8;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_REMOVE = 2'd2,
        OP_UPDATE = 2'd3
    } t_opcode;

    typedef enum logic [3:0] {
        S_CLEAR  = 4'b0001,
        S_IDLE   = 4'b0010,
        S_SCAN   = 4'b0100,
        S_COMMIT = 4'b1000
    } t_state;

endpackage

`default_nettype wire

[design/kvt_req_if.sv]
// Request channel of the keyed value table.
`timescale 1ns / 1ps
`default_nettype none

interface kvt_req_if;
    logic                          valid;
    logic                          ready;
    kvt_pkg::t_opcode              opcode;
    logic [kvt_pkg::KEY_W-1:0]     key;
    logic [kvt_pkg::VAL_W-1:0]     value_in;

    modport source (output valid, output opcode, output key, output value_in, input ready);
    modport sink (input valid, input opcode, input key, input value_in, output ready);
endinterface

`default_nettype wire

[design/kvt_rsp_if.sv]
// Response channel of the keyed value table.
`timescale 1ns / 1ps
`default_nettype none

interface kvt_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          success;
    logic [kvt_pkg::VAL_W-1:0]     value_out;

    modport source (output valid, output success, output value_out, input ready);
    modport sink (input valid, input success, input value_out, output ready);
endinterface

`default_nettype wire

[design/keyed_value_table.sv]
// Keyed value table: one item at a time, linear scan of a key and a value memory.
// Nonzero key: S_SCAN reads every entry, then S_COMMIT registers the result; the next item waits for it.
// Key zero skips the scan and goes straight to S_COMMIT, which registers a failed result.
// The scan reads one memory entry per cycle through the single read port.
// After reset a clearing pass (S_CLEAR) zeroes both memories; no item is taken then.
`timescale 1ns / 1ps
`default_nettype none

`include "keyed_value_table_assert.svh"

module keyed_value_table #(
    parameter int ENTRIES = 32
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    kvt_req_if.sink    i_req,
    kvt_rsp_if.source  o_rsp
);

    localparam int AW = $clog2(ENTRIES);
    localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);

    logic [kvt_pkg::KEY_W-1:0] key_mem [ENTRIES];
    logic [kvt_pkg::VAL_W-1:0] val_mem [ENTRIES];

    kvt_pkg::t_state           r_state;
    logic [AW-1:0]             r_idx;
    logic                      r_issue;
    logic                      r_cmp_vld;
    logic [AW-1:0]             r_cmp_idx;
    logic [kvt_pkg::KEY_W-1:0] r_key_rd;
    logic [kvt_pkg::VAL_W-1:0] r_val_rd;

    kvt_pkg::t_opcode          r_op;
    logic [kvt_pkg::KEY_W-1:0] r_key;
    logic [kvt_pkg::VAL_W-1:0] r_val;

    logic                      r_hit;
    logic [AW-1:0]             r_hit_idx;
    logic [kvt_pkg::VAL_W-1:0] r_hit_val;
    logic                      r_free;
    logic [AW-1:0]             r_free_idx;

    logic                      r_out_vld;
    logic                      r_out_ok;
    logic [kvt_pkg::VAL_W-1:0] r_out_val;

    logic                      out_free;
    logic                      commit;
    logic                      n_ok;
    logic [kvt_pkg::VAL_W-1:0] n_rd;
    logic                      key_we;
    logic                      val_we;
    logic [AW-1:0]             wr_idx;
    logic [kvt_pkg::KEY_W-1:0] key_wd;
    logic [kvt_pkg::VAL_W-1:0] val_wd;
    logic                      key_nz;
    logic                      cmp_match;
    logic                      cmp_empty;

    assign i_req.ready     = (r_state == kvt_pkg::S_IDLE);
    assign o_rsp.valid     = r_out_vld;
    assign o_rsp.success   = r_out_ok;
    assign o_rsp.value_out = r_out_val;

    assign out_free  = !r_out_vld || o_rsp.ready;
    assign commit    = (r_state == kvt_pkg::S_COMMIT) && out_free;
    assign key_nz    = (r_key != '0);
    assign cmp_match = r_cmp_vld && key_nz && (r_key_rd == r_key);
    assign cmp_empty = r_cmp_vld && (r_key_rd == '0);

    always_comb begin
        n_ok   = 1'b0;
        n_rd   = '0;
        key_we = 1'b0;
        val_we = 1'b0;
        wr_idx = r_hit_idx;
        key_wd = '0;
        val_wd = '0;
        if (r_state == kvt_pkg::S_CLEAR) begin
            key_we = 1'b1;
            val_we = 1'b1;
            wr_idx = r_idx;
        end else if (commit && key_nz) begin
            unique case (r_op)
                kvt_pkg::OP_INSERT: begin
                    n_ok   = !r_hit && r_free;
                    key_we = n_ok;
                    val_we = n_ok;
                    wr_idx = r_free_idx;
                    key_wd = r_key;
                    val_wd = r_val;
                end
                kvt_pkg::OP_LOOKUP: begin
                    n_ok = r_hit;
                    n_rd = r_hit ? r_hit_val : '0;
                end
                kvt_pkg::OP_REMOVE: begin
                    n_ok   = r_hit;
                    key_we = r_hit;
                    val_we = r_hit;
                end
                kvt_pkg::OP_UPDATE: begin
                    n_ok   = r_hit;
                    val_we = r_hit;
                    val_wd = r_val;
                end
                default: begin
                    n_ok = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (key_we) begin
            key_mem[wr_idx] <= key_wd;
        end
        if (val_we) begin
            val_mem[wr_idx] <= val_wd;
        end
        if (r_state == kvt_pkg::S_SCAN && r_issue) begin
            r_key_rd <= key_mem[r_idx];
            r_val_rd <= val_mem[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= kvt_pkg::S_CLEAR;
            r_idx     <= '0;
            r_issue   <= 1'b0;
            r_cmp_vld <= 1'b0;
            r_hit     <= 1'b0;
            r_free    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_rsp.ready) begin
                r_out_vld <= 1'b0;
            end
            unique case (r_state)
                kvt_pkg::S_CLEAR: begin
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == LAST) begin
                        r_idx   <= '0;
                        r_state <= kvt_pkg::S_IDLE;
                    end
                end
                kvt_pkg::S_IDLE: begin
                    if (i_req.valid) begin
                        r_op    <= i_req.opcode;
                        r_key   <= i_req.key;
                        r_val   <= i_req.value_in;
                        r_hit   <= 1'b0;
                        r_free  <= 1'b0;
                        r_idx   <= '0;
                        r_issue <= (i_req.key != '0);
                        r_state <= (i_req.key != '0) ? kvt_pkg::S_SCAN : kvt_pkg::S_COMMIT;
                    end
                end
                kvt_pkg::S_SCAN: begin
                    r_cmp_vld <= r_issue;
                    r_cmp_idx <= r_idx;
                    if (r_issue) begin
                        r_idx <= r_idx + 1'b1;
                        if (r_idx == LAST) begin
                            r_issue <= 1'b0;
                        end
                    end
                    if (cmp_match && !r_hit) begin
                        r_hit     <= 1'b1;
                        r_hit_idx <= r_cmp_idx;
                        r_hit_val <= r_val_rd;
                    end
                    if (cmp_empty && !r_free) begin
                        r_free     <= 1'b1;
                        r_free_idx <= r_cmp_idx;
                    end
                    if (r_cmp_vld && r_cmp_idx == LAST) begin
                        r_cmp_vld <= 1'b0;
                        r_state   <= kvt_pkg::S_COMMIT;
                    end
                end
                kvt_pkg::S_COMMIT: begin
                    if (out_free) begin
                        r_out_vld <= 1'b1;
                        r_out_ok  <= n_ok;
                        r_out_val <= n_rd;
                        r_state   <= kvt_pkg::S_IDLE;
                    end
                end
                default: begin
                    r_state <= kvt_pkg::S_CLEAR;
                    r_idx   <= '0;
                end
            endcase
        end
    end

    `KVT_NEVER(a_no_write_in_scan, i_clk, i_rst_n, (r_state == kvt_pkg::S_SCAN) && (key_we || val_we), "memory written during scan")
    `KVT_ASSERT(a_last_cmp_commits, i_clk, i_rst_n, (r_state == kvt_pkg::S_SCAN) && r_cmp_vld && (r_cmp_idx == LAST) |=> (r_state == kvt_pkg::S_COMMIT), "scan end did not commit")
    `KVT_NEVER(a_key_zero_fails, i_clk, i_rst_n, commit && !key_nz && (n_ok || key_we || val_we), "key zero changed table or succeeded")
    `KVT_ASSERT(a_result_from_commit, i_clk, i_rst_n, $rose(r_out_vld) |-> $past(r_state == kvt_pkg::S_COMMIT), "result without commit")
    `KVT_NEVER(a_insert_dup, i_clk, i_rst_n, commit && (r_op == kvt_pkg::OP_INSERT) && n_ok && r_hit, "insert of present key")

endmodule

`default_nettype wire
